### hdl/hte_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers of the hover thrust estimator
package hte_pkg;

  // fixed formats and constants
  localparam logic [15:0] HOVER_LO    = 16'd3277;
  localparam logic [15:0] HOVER_HI    = 16'd62259;
  localparam logic [63:0] COV_INIT    = 64'd1000000 << 24;
  localparam logic [16:0] FORGET_ONE  = 17'd65536;
  localparam logic [16:0] THRUST_ONE  = 17'd65536;
  localparam int          CFG_DATA_W  = 24;
  localparam int          CFG_IDX_W   = 3;
  localparam int          DIV_ITER_W  = 8;
  localparam logic [DIV_ITER_W-1:0] ITER_FULL = 8'd128;
  localparam logic [DIV_ITER_W-1:0] ITER_EST  = 8'd64;
  localparam logic [DIV_ITER_W-1:0] ITER_GAIN = 8'd41;

  // register reset values
  localparam logic [23:0] GRAVITY_RST   = 24'd642908;
  localparam logic [15:0] INIT_HOV_RST  = 16'd32768;
  localparam logic [19:0] DLY_MIN_RST   = 20'd0;
  localparam logic [19:0] DLY_MAX_RST   = 20'd500000;
  localparam logic [16:0] FORGET_RST    = 17'd65405;
  localparam logic [15:0] HOV_MIN_RST   = 16'd3277;
  localparam logic [15:0] HOV_MAX_RST   = 16'd58982;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY   = 3'd0,
    REG_INIT_HOV  = 3'd1,
    REG_DLY_MIN   = 3'd2,
    REG_DLY_MAX   = 3'd3,
    REG_FORGET    = 3'd4,
    REG_HOV_MIN   = 3'd5,
    REG_HOV_MAX   = 3'd6
  } cfg_reg_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_NO_ENTRY   = 3'd1,
    ST_TOO_RECENT = 3'd2,
    ST_BAD_ACCEL  = 3'd3,
    ST_NUMERIC    = 3'd4,
    ST_RECORDED   = 3'd5
  } status_t;

  // which operation the shared units serve
  typedef enum logic [2:0] {
    U_INIT, U_DEN, U_NUM, U_PN, U_KN, U_EST, U_GAIN
  } unit_sel_t;

  // controller states
  typedef enum logic [4:0] {
    S_INIT, S_INIT_DIV, S_INIT_WAIT, S_IDLE, S_DECODE, S_REC, S_ACC,
    S_FETCH, S_CHECK, S_SMUL, S_DEN, S_DEN_WAIT, S_NUM, S_NUM_WAIT,
    S_PN, S_PN_WAIT, S_KN, S_KN_WAIT, S_KCHK, S_EST, S_EST_WAIT,
    S_ECHK, S_GAIN, S_GAIN_WAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic                 action;
    logic [16:0]          thrust_cmd;
    logic signed [31:0]   accel_z;
    logic [31:0]          timestamp_us;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic                 clamped;
    logic [31:0]          gain_estimate;
    logic [15:0]          hover_estimate;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       cfg_write;
    logic       init_load;
    logic       push;
    logic       pop;
    logic       take_entry;
    logic       small_mul;
    logic       mul_start;
    logic       div_start;
    logic       latch;
    unit_sel_t  sel;
    logic       set_status;
    status_t    status_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_rec;
    logic acc_bad;
    logic empty;
    logic too_old;
    logic too_recent;
    logic zero_k;
    logic zero_h;
    logic cfg_known;
    logic mul_done;
    logic div_done;
  } dp_status_t;

  // saturate a 64 bit quotient to 32 bits
  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

### hdl/hte_div.sv
`timescale 1ns / 1ps
// radix-2 restoring divider with round-half-up and 64 bit saturation
module hte_div
  import hte_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [127:0]          num,
  input  logic [127:0]          den,
  input  logic [DIV_ITER_W-1:0] iters,
  output logic                  done,
  output logic [63:0]           quot
);

  logic                  run;
  logic [DIV_ITER_W-1:0] cnt;
  logic [127:0]          rem;
  logic [127:0]          nsh;
  logic [127:0]          dreg;
  logic [63:0]           q;
  logic                  ovf;
  logic [127:0]          n0;
  logic [DIV_ITER_W-1:0] shamt;
  logic [127:0]          rem_sh;
  logic                  ge;

  // rounding bias and alignment of the top numerator bit
  always_comb begin
    n0     = num + {1'b0, den[127:1]};
    shamt  = ITER_FULL - iters;
    rem_sh = {rem[126:0], nsh[127]};
    ge     = (rem_sh >= dreg);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= iters;
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_ITER_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= n0 << shamt[6:0];
      dreg <= den;
      rem  <= '0;
      q    <= '0;
      ovf  <= 1'b0;
    end else if (run) begin
      nsh <= {nsh[126:0], 1'b0};
      rem <= ge ? (rem_sh - dreg) : rem_sh;
      q   <= {q[62:0], ge};
      ovf <= ovf | q[63];
    end
  end

  assign quot = ovf ? 64'hFFFF_FFFF_FFFF_FFFF : q;

endmodule

### hdl/hte_mul.sv
`timescale 1ns / 1ps
// shift-add 64 by 64 multiplier, one multiplier bit a cycle
module hte_mul
  import hte_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic         run;
  logic [6:0]   cnt;
  logic [127:0] ash;
  logic [63:0]  bsh;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 7'd64;
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // accumulate shifted multiplicand
  always_ff @(posedge clk) begin
    if (start) begin
      ash  <= {64'd0, a};
      bsh  <= b;
      prod <= '0;
    end else if (run) begin
      if (bsh[0]) prod <= prod + ash;
      ash <= {ash[126:0], 1'b0};
      bsh <= {1'b0, bsh[63:1]};
    end
  end

endmodule

### hdl/hte_dp.sv
`timescale 1ns / 1ps
// datapath: registers, command fifo, estimator state and arithmetic units
module hte_dp
  import hte_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  in_item_t              in_item,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output dp_status_t            st,
  output out_item_t             result
);

  localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int ENT_W = 17 + 32;

  // configuration registers
  logic [23:0] gravity;
  logic [15:0] initial_hover;
  logic [19:0] delay_min_us;
  logic [19:0] delay_max_us;
  logic [16:0] forget_factor;
  logic [15:0] hover_min;
  logic [15:0] hover_max;

  in_item_t item;

  // command fifo
  logic [ENT_W-1:0] mem [FIFO_DEPTH];
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [ENT_W-1:0] rd;
  logic [16:0]      rd_thrust;
  logic [31:0]      rd_time;
  logic             full;
  logic [SUM_W-1:0] slot_sum;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] head_inc;
  logic [16:0]      thr_sat;
  logic             do_push;

  // estimator and work registers
  logic [31:0]  gain_reg;
  logic [63:0]  covariance_reg;
  logic [15:0]  hover_reg;
  logic [16:0]  t;
  logic [16:0]  r;
  logic [33:0]  tt;
  logic [47:0]  ta;
  logic [48:0]  rg;
  logic [127:0] den;
  logic [127:0] num;
  logic [63:0]  pn;
  logic [63:0]  kn;
  logic [63:0]  est;
  logic [15:0]  b;
  status_t      res_status;
  logic         res_clamped;

  // unit hookup
  logic [63:0]           mul_b;
  logic [127:0]          mul_p;
  logic                  mul_done;
  logic [127:0]          div_n;
  logic [127:0]          div_d;
  logic [DIV_ITER_W-1:0] div_it;
  logic [63:0]           div_q;
  logic                  div_done;
  logic [127:0]          grav_sh;
  logic [15:0]           b_next;
  logic [15:0]           h0;
  logic [16:0]           r_next;
  logic [31:0]           diff;
  logic signed [32:0]    elapsed;

  // fifo addressing and entry split
  always_comb begin
    full      = (count == CNT_W'(FIFO_DEPTH));
    slot_sum  = SUM_W'(head) + SUM_W'(count);
    if (slot_sum >= SUM_W'(FIFO_DEPTH)) slot_sum = slot_sum - SUM_W'(FIFO_DEPTH);
    slot      = full ? head : slot_sum[IDX_W-1:0];
    head_inc  = (head == IDX_W'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
    thr_sat   = (item.thrust_cmd > THRUST_ONE) ? THRUST_ONE : item.thrust_cmd;
    do_push   = cmd.push && (thr_sat != 17'd0);
    rd_thrust = rd[ENT_W-1:32];
    rd_time   = rd[31:0];
  end

  // fifo storage
  always_ff @(posedge clk) begin
    if (do_push) mem[slot] <= {thr_sat, item.timestamp_us};
    rd <= mem[head];
  end

  // fifo pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.init_load) begin
      head  <= '0;
      count <= '0;
    end else if (do_push) begin
      if (full) head <= head_inc;
      else count <= count + 1'b1;
    end else if (cmd.pop) begin
      head  <= head_inc;
      count <= count - 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity       <= GRAVITY_RST;
      initial_hover <= INIT_HOV_RST;
      delay_min_us  <= DLY_MIN_RST;
      delay_max_us  <= DLY_MAX_RST;
      forget_factor <= FORGET_RST;
      hover_min     <= HOV_MIN_RST;
      hover_max     <= HOV_MAX_RST;
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        REG_GRAVITY:  gravity       <= cfg_data[23:0];
        REG_INIT_HOV: initial_hover <= cfg_data[15:0];
        REG_DLY_MIN:  delay_min_us  <= cfg_data[19:0];
        REG_DLY_MAX:  delay_max_us  <= cfg_data[19:0];
        REG_FORGET:   forget_factor <= cfg_data[16:0];
        REG_HOV_MIN:  hover_min     <= cfg_data[15:0];
        REG_HOV_MAX:  hover_max     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // clamps, age of the head entry, unit operands
  always_comb begin
    grav_sh = {88'd0, gravity, 16'd0};
    h0      = (initial_hover < HOVER_LO) ? HOVER_LO :
              (initial_hover > HOVER_HI) ? HOVER_HI : initial_hover;
    r_next  = (forget_factor == 17'd0) ? 17'd1 :
              (forget_factor > FORGET_ONE) ? FORGET_ONE : forget_factor;
    b_next  = (div_q < 64'(hover_min)) ? hover_min :
              (div_q > 64'(hover_max)) ? hover_max : div_q[15:0];
    diff    = item.timestamp_us - rd_time;
    elapsed = {diff[31], diff};
    mul_b   = (cmd.sel == U_NUM) ? 64'(ta) : 64'(tt);
    unique case (cmd.sel)
      U_INIT: begin
        div_n = grav_sh;                  div_d = 128'(hover_reg); div_it = ITER_GAIN;
      end
      U_PN: begin
        div_n = {8'd0, covariance_reg, 56'd0}; div_d = den;   div_it = ITER_FULL;
      end
      U_KN: begin
        div_n = {num[111:0], 16'd0};      div_d = den;             div_it = ITER_FULL;
      end
      U_EST: begin
        div_n = grav_sh;                  div_d = 128'(kn);        div_it = ITER_EST;
      end
      U_GAIN: begin
        div_n = grav_sh;                  div_d = 128'(b);         div_it = ITER_GAIN;
      end
      default: begin
        div_n = '0;                       div_d = den;             div_it = ITER_FULL;
      end
    endcase
  end

  // item, entry operands and small products
  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_item;
    if (cmd.take_entry) begin
      t <= rd_thrust;
      r <= r_next;
    end
    if (cmd.small_mul) begin
      tt <= t * t;
      ta <= t * item.accel_z[30:0];
      rg <= r * gain_reg;
    end
  end

  // estimator state and unit results
  always_ff @(posedge clk) begin
    if (cmd.load_item) res_clamped <= 1'b0;
    if (cmd.set_status) res_status <= cmd.status_code;
    if (cmd.init_load) begin
      hover_reg      <= h0;
      covariance_reg <= COV_INIT;
    end else if (cmd.latch) begin
      unique case (cmd.sel)
        U_INIT: gain_reg <= sat32(div_q);
        U_DEN:  den <= 128'({r, 40'd0}) + mul_p;
        U_NUM:  num <= 128'({rg, 24'd0}) + mul_p;
        U_PN:   pn  <= div_q;
        U_KN:   kn  <= div_q;
        U_EST: begin
          est <= div_q;
          b   <= b_next;
        end
        U_GAIN: begin
          gain_reg       <= sat32(div_q);
          covariance_reg <= pn;
          hover_reg      <= b;
          res_clamped    <= (64'(b) != est);
        end
        default: ;
      endcase
    end
  end

  hte_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (covariance_reg),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  hte_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_n),
    .den   (div_d),
    .iters (div_it),
    .done  (div_done),
    .quot  (div_q)
  );

  // status back to the controller
  always_comb begin
    st.is_rec     = !item.action;
    st.acc_bad    = (item.accel_z == 32'sd0) || item.accel_z[31] || (gravity == 24'd0);
    st.empty      = (count == '0);
    st.too_old    = elapsed > $signed({13'd0, delay_max_us});
    st.too_recent = elapsed < $signed({13'd0, delay_min_us});
    st.zero_k     = (kn == 64'd0) || (pn == 64'd0);
    st.zero_h     = (est == 64'd0) || (b == 16'd0);
    st.cfg_known  = (cfg_index <= REG_HOV_MAX);
    st.mul_done   = mul_done;
    st.div_done   = div_done;
  end

  assign result.status         = res_status;
  assign result.clamped        = res_clamped;
  assign result.gain_estimate  = gain_reg;
  assign result.hover_estimate = hover_reg;

  // fill level stays within the fifo
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("fifo count beyond depth");

  // a pop on a non-empty fifo with no push or init load removes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop && !cmd.push && !cmd.init_load && count != '0) |=>
      count == $past(count) - 1'b1)
    else $error("pop did not reduce fill level");

  // the head entry is only taken from a filled fifo
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("pop on an empty fifo");

endmodule

### hdl/hte_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences record, sample and re-initialisation steps
module hte_ctrl
  import hte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       cfg_valid,
  input  dp_status_t st,
  output logic       busy,
  output logic       cfg_ready,
  output logic       result_valid,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:      state_next = S_INIT_DIV;
      S_INIT_DIV:  state_next = S_INIT_WAIT;
      S_INIT_WAIT: if (st.div_done) state_next = S_IDLE;
      S_IDLE: begin
        if (start) state_next = S_DECODE;
        else if (cfg_valid && st.cfg_known) state_next = S_INIT;
      end
      S_DECODE:    state_next = st.is_rec ? S_REC : S_ACC;
      S_REC:       state_next = S_OUT;
      S_ACC:       state_next = st.acc_bad ? S_OUT : S_FETCH;
      S_FETCH:     state_next = st.empty ? S_OUT : S_CHECK;
      S_CHECK: begin
        priority if (st.too_old) state_next = S_FETCH;
        else if (st.too_recent) state_next = S_OUT;
        else state_next = S_SMUL;
      end
      S_SMUL:      state_next = S_DEN;
      S_DEN:       state_next = S_DEN_WAIT;
      S_DEN_WAIT:  if (st.mul_done) state_next = S_NUM;
      S_NUM:       state_next = S_NUM_WAIT;
      S_NUM_WAIT:  if (st.mul_done) state_next = S_PN;
      S_PN:        state_next = S_PN_WAIT;
      S_PN_WAIT:   if (st.div_done) state_next = S_KN;
      S_KN:        state_next = S_KN_WAIT;
      S_KN_WAIT:   if (st.div_done) state_next = S_KCHK;
      S_KCHK:      state_next = st.zero_k ? S_OUT : S_EST;
      S_EST:       state_next = S_EST_WAIT;
      S_EST_WAIT:  if (st.div_done) state_next = S_ECHK;
      S_ECHK:      state_next = st.zero_h ? S_OUT : S_GAIN;
      S_GAIN:      state_next = S_GAIN_WAIT;
      S_GAIN_WAIT: if (st.div_done) state_next = S_OUT;
      S_OUT:       state_next = S_IDLE;
      default:     state_next = S_INIT;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.sel      = U_INIT;
    busy         = (state != S_IDLE);
    cfg_ready    = (state == S_IDLE) && !start;
    result_valid = (state == S_OUT);
    unique case (state)
      S_INIT:      cmd.init_load = 1'b1;
      S_INIT_DIV:  cmd.div_start = 1'b1;
      S_INIT_WAIT: cmd.latch = st.div_done;
      S_IDLE: begin
        cmd.load_item = start;
        cmd.cfg_write = cfg_valid && !start;
      end
      S_REC: begin
        cmd.push        = 1'b1;
        cmd.set_status  = 1'b1;
        cmd.status_code = ST_RECORDED;
      end
      S_ACC: begin
        cmd.set_status  = st.acc_bad;
        cmd.status_code = ST_BAD_ACCEL;
      end
      S_FETCH: begin
        cmd.set_status  = st.empty;
        cmd.status_code = ST_NO_ENTRY;
      end
      S_CHECK: begin
        priority if (st.too_old) begin
          cmd.pop = 1'b1;
        end else if (st.too_recent) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_TOO_RECENT;
        end else begin
          cmd.pop        = 1'b1;
          cmd.take_entry = 1'b1;
        end
      end
      S_SMUL:      cmd.small_mul = 1'b1;
      S_DEN: begin
        cmd.sel = U_DEN; cmd.mul_start = 1'b1;
      end
      S_DEN_WAIT: begin
        cmd.sel = U_DEN; cmd.latch = st.mul_done;
      end
      S_NUM: begin
        cmd.sel = U_NUM; cmd.mul_start = 1'b1;
      end
      S_NUM_WAIT: begin
        cmd.sel = U_NUM; cmd.latch = st.mul_done;
      end
      S_PN: begin
        cmd.sel = U_PN; cmd.div_start = 1'b1;
      end
      S_PN_WAIT: begin
        cmd.sel = U_PN; cmd.latch = st.div_done;
      end
      S_KN: begin
        cmd.sel = U_KN; cmd.div_start = 1'b1;
      end
      S_KN_WAIT: begin
        cmd.sel = U_KN; cmd.latch = st.div_done;
      end
      S_KCHK: begin
        cmd.set_status  = st.zero_k;
        cmd.status_code = ST_NUMERIC;
      end
      S_EST: begin
        cmd.sel = U_EST; cmd.div_start = 1'b1;
      end
      S_EST_WAIT: begin
        cmd.sel = U_EST; cmd.latch = st.div_done;
      end
      S_ECHK: begin
        cmd.set_status  = st.zero_h;
        cmd.status_code = ST_NUMERIC;
      end
      S_GAIN: begin
        cmd.sel = U_GAIN; cmd.div_start = 1'b1;
      end
      S_GAIN_WAIT: begin
        cmd.sel         = U_GAIN;
        cmd.latch       = st.div_done;
        cmd.set_status  = st.div_done;
        cmd.status_code = ST_UPDATED;
      end
      default: ;
    endcase
  end

  // a result strobe lasts one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  // an accepted item keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // no config beat while an item is taken
  a_cfg_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.cfg_write && cmd.load_item))
    else $error("config write and item accept in one cycle");

endmodule

### hdl/hover_thrust_rls_estimator.sv
`timescale 1ns / 1ps
// top level of the hover thrust recursive least squares estimator
//
//  channel   handshake                 payload
//  -------   ------------------------  ---------------------------------
//  input     start & !busy             in_item (action, thrust, accel, time)
//  result    result_valid, 1 cycle     result (status, clamped, gain, hover)
//  config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
// a record item passes through the decode, record and output states before its result.
// a sample item that updates runs two shift-add multiplies and four divisions of
// 128, 128, 64 and 41 steps in the shared divider, plus a fetch and a check state
// for each fifo entry discarded as too old; rejects finish early.
// reset and every known config write start a re-initialisation (one gain division),
// with busy high and cfg_ready low meanwhile.
// result beats cannot be held off; one item is in work at a time.
module hover_thrust_rls_estimator
  import hte_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  result_valid,
  output out_item_t             result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t       cmd;
  dp_status_t st;

  hte_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cfg_valid    (cfg_valid),
    .st           (st),
    .busy         (busy),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  hte_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .st        (st),
    .result    (result)
  );

endmodule
